/* hdl/pht_pkg.sv */
// Shared types and constants for the pointer hash table tracker.
// Holds payload structs, command/status structs, state and op enums.
// No dependencies.
package pht_pkg;

   localparam int KEY_W      = 48;
   localparam int SIZE_W     = 32;
   localparam int SERIAL_W   = 32;
   localparam int TALLY_W    = 40;
   localparam int LIVE_W     = 9;
   localparam int MIX_SHIFT  = 33;
   localparam logic [63:0] MIX_MULT = 64'hff51afd7ed558ccd;

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_IGNORED    = 3'd0,
      ST_INSERTED   = 3'd1,
      ST_REPLACED   = 3'd2,
      ST_REMOVED    = 3'd3,
      ST_NOT_FOUND  = 3'd4,
      ST_TABLE_FULL = 3'd5,
      ST_CLEARED    = 3'd6
   } code_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [KEY_W-1:0]    address;
      logic [SIZE_W-1:0]   alloc_size;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [SERIAL_W-1:0] assigned_serial;
      logic [LIVE_W-1:0]   live_entries;
      logic [TALLY_W-1:0]  live_byte_total;
      logic [SERIAL_W-1:0] total_allocations;
      logic [SERIAL_W-1:0] total_frees;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [SIZE_W-1:0]   bytes;
      logic [SERIAL_W-1:0] serial;
   } slot_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLR_INIT,
      OP_CLR_STEP,
      OP_CLR_CNT,
      OP_HASH_KEY,
      OP_HASH_SLOT,
      OP_PROBE_INIT,
      OP_READ,
      OP_NEXT,
      OP_REPLACE,
      OP_INSERT,
      OP_REMOVE,
      OP_MOVE_GAP,
      OP_MOVE_CLR,
      OP_RESPOND
   } op_type;

   typedef enum logic [3:0] {
      S_RST_INIT,
      S_RST_SWEEP,
      S_IDLE,
      S_DECODE,
      S_CLR_SWEEP,
      S_CLR_CNT,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_SHIFT_RD,
      S_SHIFT_CHK,
      S_SHIFT_HASH,
      S_SHIFT_DEC,
      S_SHIFT_MOVE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      op_type   op;
      code_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic       hash_done;
      logic       rd_valid;
      logic       rd_match;
      logic       exhausted;
      logic       full;
      logic       movable;
      logic       sweep_last;
      logic       out_free;
      logic       key_null;
      logic       tracking;
      logic [1:0] mode;
   } dp_status_type;

endpackage

/* hdl/pht_hash.sv */
// Multi-cycle 64-bit mix hash giving the home slot of a key.
// One shared 32x32 multiplier over three partial products; uses pht_pkg.
module pht_hash import pht_pkg::*; #(
   parameter int SLOT_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_W-1:0]              key,
   output logic                          done,
   output logic [$clog2(SLOT_COUNT)-1:0] home
);

   localparam int IW = $clog2(SLOT_COUNT);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [1:0]       step_ff, step_in;
   logic [KEY_W-1:0] v_ff, v_in;
   logic [63:0]      prod_ff, prod_in;
   logic [63:0]      acc_ff, acc_in;
   logic [31:0]      mul_a, mul_b;

   // Pick the partial product for this step
   always_comb begin
      unique case (step_ff)
         2'd0: begin
            mul_a = v_ff[31:0];
            mul_b = MIX_MULT[31:0];
         end
         2'd1: begin
            mul_a = v_ff[31:0];
            mul_b = MIX_MULT[63:32];
         end
         2'd2: begin
            mul_a = 32'(v_ff[KEY_W-1:32]);
            mul_b = MIX_MULT[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Register each partial product, then add it into the accumulator
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      v_in    = v_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (start) begin
         v_in    = key ^ (key >> MIX_SHIFT);
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = 64'(mul_a) * 64'(mul_b);
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            2'd2: acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
            default: begin
               acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
               busy_in       = 1'b0;
               done_in       = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      v_ff    <= v_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Final xor-shift folded into the masked bits
   assign home = acc_ff[IW-1:0] ^ acc_ff[IW+MIX_SHIFT-1:MIX_SHIFT];
   assign done = done_ff;

endmodule

/* hdl/pht_datapath.sv */
// Datapath: slot memory, probe/gap pointers, tallies and result register.
// Driven by op commands from pht_ctrl; uses pht_pkg and pht_hash.
module pht_datapath import pht_pkg::*; #(
   parameter int SLOT_COUNT = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          csr_write_en,
   input  logic          csr_write_data,
   input  dp_cmd_type    cmd,
   output dp_status_type stat,
   output rsp_type       rsp_data,
   output logic          rsp_valid,
   input  logic          rsp_ready
);

   localparam int IW    = $clog2(SLOT_COUNT);
   localparam int CW    = IW + 1;
   localparam int LIMIT = SLOT_COUNT * 3 / 4;

   slot_type mem [SLOT_COUNT];

   req_type             item_ff, item_in;
   logic                tracking_ff, tracking_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       gap_ff, gap_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TALLY_W-1:0]  tally_ff, tally_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;
   logic [SERIAL_W-1:0] asg_ff, asg_in;
   slot_type            rd_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   slot_type            wr_data;
   logic                hash_start, hash_done;
   logic [KEY_W-1:0]    hash_key;
   logic [IW-1:0]       home;
   logic [SERIAL_W-1:0] serial_inc, count32, frees;
   logic [CW-1:0]       count_inc;
   logic                movable;

   assign hash_start = (cmd.op == OP_HASH_KEY) || (cmd.op == OP_HASH_SLOT);
   assign hash_key   = (cmd.op == OP_HASH_SLOT) ? rd_ff.key : item_ff.address;

   pht_hash #(.SLOT_COUNT(SLOT_COUNT)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .home  (home)
   );

   assign serial_inc = serial_ff + 32'd1;
   assign count_inc  = count_ff + CW'(1);
   assign count32    = 32'(count_ff);
   assign frees      = (serial_ff >= count32) ? (serial_ff - count32) : '0;

   // Can the entry at idx move back into the gap?
   always_comb begin
      if (gap_ff <= idx_ff) begin
         movable = !((gap_ff < home) && (home <= idx_ff));
      end else begin
         movable = !((gap_ff < home) || (home <= idx_ff));
      end
   end

   // Status to the controller
   always_comb begin
      stat.hash_done  = hash_done;
      stat.rd_valid   = rd_ff.valid;
      stat.rd_match   = (rd_ff.key == item_ff.address);
      stat.exhausted  = (n_ff == CW'(SLOT_COUNT));
      stat.full       = (count_inc >= CW'(LIMIT));
      stat.movable    = movable;
      stat.sweep_last = (idx_ff == {IW{1'b1}});
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.key_null   = (item_ff.address == '0);
      stat.tracking   = tracking_ff;
      stat.mode       = item_ff.mode;
   end

   // Memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_ff;
      unique case (cmd.op)
         OP_CLR_STEP: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         OP_REPLACE, OP_INSERT: begin
            wr_en   = 1'b1;
            wr_data = '{valid: 1'b1, key: item_ff.address,
                        bytes: item_ff.alloc_size, serial: serial_inc};
         end
         OP_REMOVE, OP_MOVE_CLR: begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b0;
         end
         OP_MOVE_GAP: begin
            wr_en   = 1'b1;
            wr_addr = gap_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.op == OP_READ) begin
         rd_ff <= mem[idx_ff];
      end
   end

   // Pointer, tally and result updates
   always_comb begin
      item_in      = item_ff;
      tracking_in  = csr_write_en ? csr_write_data : tracking_ff;
      idx_in       = idx_ff;
      gap_in       = gap_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      tally_in     = tally_ff;
      serial_in    = serial_ff;
      asg_in       = asg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (cmd.op)
         OP_LOAD: begin
            item_in = req_data;
            asg_in  = '0;
         end
         OP_CLR_INIT: idx_in = '0;
         OP_CLR_STEP: idx_in = idx_ff + IW'(1);
         OP_CLR_CNT: begin
            count_in  = '0;
            tally_in  = '0;
            serial_in = '0;
         end
         OP_PROBE_INIT: begin
            idx_in = home;
            n_in   = '0;
         end
         OP_NEXT: begin
            idx_in = idx_ff + IW'(1);
            n_in   = n_ff + CW'(1);
         end
         OP_REPLACE: begin
            serial_in = serial_inc;
            asg_in    = serial_inc;
            tally_in  = tally_ff - TALLY_W'(rd_ff.bytes) + TALLY_W'(item_ff.alloc_size);
         end
         OP_INSERT: begin
            serial_in = serial_inc;
            asg_in    = serial_inc;
            count_in  = count_inc;
            tally_in  = tally_ff + TALLY_W'(item_ff.alloc_size);
         end
         OP_REMOVE: begin
            tally_in = tally_ff - TALLY_W'(rd_ff.bytes);
            count_in = count_ff - CW'(1);
            gap_in   = idx_ff;
            idx_in   = idx_ff + IW'(1);
            n_in     = '0;
         end
         OP_MOVE_CLR: begin
            gap_in = idx_ff;
            idx_in = idx_ff + IW'(1);
            n_in   = n_ff + CW'(1);
         end
         OP_RESPOND: begin
            rsp_in.status            = cmd.code;
            rsp_in.assigned_serial   = asg_ff;
            rsp_in.live_entries      = count32[LIVE_W-1:0];
            rsp_in.live_byte_total   = tally_ff;
            rsp_in.total_allocations = serial_ff;
            rsp_in.total_frees       = frees;
            rsp_valid_in             = 1'b1;
         end
         default: begin
            item_in = item_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff  <= 1'b1;
         count_ff     <= '0;
         tally_ff     <= '0;
         serial_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tracking_ff  <= tracking_in;
         count_ff     <= count_in;
         tally_ff     <= tally_in;
         serial_ff    <= serial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      idx_ff  <= idx_in;
      gap_ff  <= gap_in;
      n_ff    <= n_in;
      asg_ff  <= asg_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/pht_ctrl.sv */
// Controller state machine: sequences clear, probe, insert, remove and shift walk.
// Issues op commands to pht_datapath; uses pht_pkg.
module pht_ctrl import pht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   code_type  code_ff, code_in;
   logic      is_alloc;

   assign is_alloc = (stat.mode == MODE_ALLOC);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_RST_INIT:  state_in = S_RST_SWEEP;
         S_RST_SWEEP: if (stat.sweep_last) state_in = S_IDLE;
         S_IDLE:      if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            priority if (stat.mode == MODE_CLEAR) begin
               state_in = S_CLR_SWEEP;
            end else if (is_alloc && !stat.key_null && stat.tracking) begin
               state_in = S_HASH;
            end else if ((stat.mode == MODE_FREE) && !stat.key_null) begin
               state_in = S_HASH;
            end else begin
               state_in = S_RESPOND;
            end
         end
         S_CLR_SWEEP: if (stat.sweep_last) state_in = S_CLR_CNT;
         S_CLR_CNT:   state_in = S_RESPOND;
         S_HASH:      if (stat.hash_done) state_in = S_PROBE_RD;
         S_PROBE_RD:  state_in = stat.exhausted ? S_RESPOND : S_PROBE_CHK;
         S_PROBE_CHK: begin
            priority if (!stat.rd_valid) begin
               state_in = S_RESPOND;
            end else if (stat.rd_match) begin
               state_in = is_alloc ? S_RESPOND : S_SHIFT_RD;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_SHIFT_RD:   state_in = stat.exhausted ? S_RESPOND : S_SHIFT_CHK;
         S_SHIFT_CHK:  state_in = stat.rd_valid ? S_SHIFT_HASH : S_RESPOND;
         S_SHIFT_HASH: if (stat.hash_done) state_in = S_SHIFT_DEC;
         S_SHIFT_DEC:  state_in = stat.movable ? S_SHIFT_MOVE : S_SHIFT_RD;
         S_SHIFT_MOVE: state_in = S_SHIFT_RD;
         S_RESPOND:    if (stat.out_free) state_in = S_IDLE;
         default:      state_in = S_RST_INIT;
      endcase
   end

   // Outputs and result code
   always_comb begin
      cmd.op    = OP_NONE;
      code_in   = code_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_RST_INIT:  cmd.op = OP_CLR_INIT;
         S_RST_SWEEP: cmd.op = OP_CLR_STEP;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_DECODE: begin
            priority if (stat.mode == MODE_CLEAR) begin
               cmd.op = OP_CLR_INIT;
            end else if (is_alloc && !stat.key_null && stat.tracking) begin
               cmd.op = OP_HASH_KEY;
            end else if ((stat.mode == MODE_FREE) && !stat.key_null) begin
               cmd.op = OP_HASH_KEY;
            end else begin
               code_in = ST_IGNORED;
            end
         end
         S_CLR_SWEEP: cmd.op = OP_CLR_STEP;
         S_CLR_CNT: begin
            cmd.op  = OP_CLR_CNT;
            code_in = ST_CLEARED;
         end
         S_HASH: if (stat.hash_done) cmd.op = OP_PROBE_INIT;
         S_PROBE_RD: begin
            if (stat.exhausted) begin
               code_in = is_alloc ? ST_TABLE_FULL : ST_NOT_FOUND;
            end else begin
               cmd.op = OP_READ;
            end
         end
         S_PROBE_CHK: begin
            priority if (!stat.rd_valid) begin
               priority if (!is_alloc) begin
                  code_in = ST_NOT_FOUND;
               end else if (stat.full) begin
                  code_in = ST_TABLE_FULL;
               end else begin
                  cmd.op  = OP_INSERT;
                  code_in = ST_INSERTED;
               end
            end else if (stat.rd_match) begin
               if (is_alloc) begin
                  cmd.op  = OP_REPLACE;
                  code_in = ST_REPLACED;
               end else begin
                  cmd.op  = OP_REMOVE;
                  code_in = ST_REMOVED;
               end
            end else begin
               cmd.op = OP_NEXT;
            end
         end
         S_SHIFT_RD:  if (!stat.exhausted) cmd.op = OP_READ;
         S_SHIFT_CHK: if (stat.rd_valid) cmd.op = OP_HASH_SLOT;
         S_SHIFT_DEC: cmd.op = stat.movable ? OP_MOVE_GAP : OP_NEXT;
         S_SHIFT_MOVE: cmd.op = OP_MOVE_CLR;
         S_RESPOND:   if (stat.out_free) cmd.op = OP_RESPOND;
         default:     cmd.op = OP_NONE;
      endcase
      cmd.code = code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RST_INIT;
         code_ff  <= ST_IGNORED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

/* hdl/pointer_hash_table_tracker.sv */
// Allocation tracker: linear-probing hash table of live allocations.
// Usage:
//   req_*  : one event item (allocation, free or clear) with valid/ready.
//   rsp_*  : one result item per event with valid/ready, held in an
//            output register until taken.
//   csr_*  : tracking enable; the user writes it only while idle (not enforced).
// Timing: one event at a time. An ignored event is decoded and then
//   answered, and the next item can be taken after it responds. A lookup
//   runs the key through the multi-cycle hash, then reads and checks one
//   slot per probe, all through the single-port slot memory.
//   A free then walks the cluster: it reads each occupied slot, re-hashes
//   its key, moves the entry back into the gap if it can, and stops at the
//   empty slot. A clear sweeps the memory and then clears the counters.
// Reset: a clearing pass runs first; req_ready stays low until it ends.
//   Counters clear and tracking is enabled.
// Stall: while a result waits on rsp_ready the next item may be accepted
//   and worked on; its result waits until the register frees.
// Uses pht_pkg, pht_ctrl, pht_datapath.
module pointer_hash_table_tracker import pht_pkg::*; #(
   parameter int SLOT_COUNT = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write_en,
   input  logic    csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   pht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pht_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_data       (rsp_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready)
   );

endmodule

/* hdl/pht_checker.sv */
// Port-level checks for the pointer hash table tracker, bound to the top.
// Uses pht_pkg.
module pht_checker import pht_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a waiting item
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("item changed while waiting");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A clear leaves an empty table and restarted counters
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_CLEARED) |->
         (rsp_data.live_entries == '0) && (rsp_data.live_byte_total == '0) &&
         (rsp_data.total_allocations == '0))
      else $error("clear left state behind");

   // Only recorded allocations carry a serial
   a_serial_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_INSERTED) &&
         (rsp_data.status != ST_REPLACED) |-> rsp_data.assigned_serial == '0)
      else $error("serial on a non-allocation result");

   // A recorded allocation takes the latest serial
   a_serial_latest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == ST_INSERTED) ||
         (rsp_data.status == ST_REPLACED)) |->
         rsp_data.assigned_serial == rsp_data.total_allocations)
      else $error("serial differs from counter");

endmodule

bind pointer_hash_table_tracker pht_checker u_checker (.*);
